### rtl/mpct_pkg.sv
// mpct_pkg: shared types, constants and helper functions for the mouse packet
// cursor tracker. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mpct_pkg;

    // register map, index = paddr / 4
    localparam int unsigned ADDR_W = 4;
    localparam logic [1:0] REG_SCALE_MODE = 2'd0;
    localparam logic [1:0] REG_X_LIMIT    = 2'd1;
    localparam logic [1:0] REG_Y_LIMIT    = 2'd2;

    localparam logic [9:0] X_LIMIT_RST  = 10'd628;
    localparam logic [8:0] Y_LIMIT_RST  = 9'd459;
    localparam logic [9:0] CURSOR_X_RST = 10'd320;
    localparam logic [8:0] CURSOR_Y_RST = 9'd240;
    localparam logic [1:0] BUTTONS_RST  = 2'b10;

    typedef struct packed {
        logic       scale_mode;
        logic [9:0] x_limit;
        logic [8:0] y_limit;
    } t_cfg;

    // signed delta, optionally divided by four truncating toward zero
    function automatic logic signed [7:0] scale_delta(input logic [7:0] b,
                                                      input logic mode);
        logic signed [7:0] d;
        logic signed [7:0] biased;
        begin
            d      = $signed(b);
            biased = d[7] ? d + 8'sd3 : d;
            scale_delta = mode ? (biased >>> 2) : d;
        end
    endfunction

    // force a signed coordinate into 0..lim
    function automatic logic [9:0] clamp_coord(input logic signed [11:0] v,
                                               input logic [9:0] lim);
        begin
            if (v[11]) begin
                clamp_coord = '0;
            end else if (v[10:0] > {1'b0, lim}) begin
                clamp_coord = lim;
            end else begin
                clamp_coord = v[9:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

### rtl/mpct_cfg_regs.sv
// mpct_cfg_regs: APB-style configuration registers (scale mode, limits).
// Depends on mpct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpct_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_psel,
    input  wire logic                       i_penable,
    input  wire logic                       i_pwrite,
    input  wire logic [mpct_pkg::ADDR_W-1:0] i_paddr,
    input  wire logic [31:0]                i_pwdata,
    output logic      [31:0]                o_prdata,
    output logic                            o_pready,
    output mpct_pkg::t_cfg                  o_cfg
);
    import mpct_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx  = i_paddr[3:2];
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_mode <= 1'b0;
            r_cfg.x_limit    <= X_LIMIT_RST;
            r_cfg.y_limit    <= Y_LIMIT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SCALE_MODE: r_cfg.scale_mode <= i_pwdata[0];
                REG_X_LIMIT:    r_cfg.x_limit    <= i_pwdata[9:0];
                REG_Y_LIMIT:    r_cfg.y_limit    <= i_pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SCALE_MODE: o_prdata = {31'd0, r_cfg.scale_mode};
            REG_X_LIMIT:    o_prdata = {22'd0, r_cfg.x_limit};
            REG_Y_LIMIT:    o_prdata = {23'd0, r_cfg.y_limit};
            default:        o_prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/mpct_core.sv
// mpct_core: input register, byte phase tracking, cursor update and result
// register. Depends on mpct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpct_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mpct_pkg::t_cfg i_cfg,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire logic [7:0]     i_s_tdata,
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    output logic      [23:0]    o_m_tdata,
    output logic      [1:0]     o_phase
);
    import mpct_pkg::*;

    localparam logic [1:0] PH_VERT = 2'd0;
    localparam logic [1:0] PH_BTN  = 2'd1;
    localparam logic [1:0] PH_HORZ = 2'd2;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic [1:0] r_phase, n_phase;
    logic [7:0] r_vdelta;
    logic [1:0] r_btn;
    logic [9:0] r_cur_x, n_cur_x;
    logic [8:0] r_cur_y, n_cur_y;
    logic       r_out_valid, n_out_valid;
    logic [9:0] r_out_x;
    logic [8:0] r_out_y;
    logic [1:0] r_out_btn;

    logic              proc_fire;
    logic              s_ready;
    logic signed [7:0]  dx, dy;
    logic signed [11:0] nx, ny;
    logic [9:0]         cy_wide;

    assign proc_fire  = r_in_valid && (!r_out_valid || i_m_tready);
    assign s_ready    = !r_in_valid || proc_fire;
    assign o_s_tready = s_ready;

    always_comb begin
        dx      = scale_delta(r_in_byte, i_cfg.scale_mode);
        dy      = scale_delta(r_vdelta, i_cfg.scale_mode);
        nx      = $signed({2'b00, r_cur_x}) + 12'(dx);
        ny      = $signed({3'b000, r_cur_y}) - 12'(dy);
        n_cur_x = clamp_coord(nx, i_cfg.x_limit);
        cy_wide = clamp_coord(ny, {1'b0, i_cfg.y_limit});
        n_cur_y = cy_wide[8:0];
    end

    // the unused phase code is taken as a first byte
    always_comb begin
        unique case (r_phase)
            PH_BTN:  n_phase = PH_HORZ;
            PH_HORZ: n_phase = PH_VERT;
            default: n_phase = PH_BTN;
        endcase
    end

    // result appears when the third byte is processed
    always_comb begin
        if (proc_fire && r_phase == PH_HORZ) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_VERT;
            r_vdelta    <= '0;
            r_btn       <= BUTTONS_RST;
            r_cur_x     <= CURSOR_X_RST;
            r_cur_y     <= CURSOR_Y_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (s_ready) begin
                r_in_valid <= i_s_tvalid;
            end
            r_out_valid <= n_out_valid;
            if (proc_fire) begin
                r_phase <= n_phase;
                unique case (r_phase)
                    PH_BTN:  r_btn <= r_in_byte[1:0];
                    PH_HORZ: begin
                        r_cur_x <= n_cur_x;
                        r_cur_y <= n_cur_y;
                    end
                    default: r_vdelta <= r_in_byte;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
        if (proc_fire && r_phase == PH_HORZ) begin
            r_out_x   <= n_cur_x;
            r_out_y   <= n_cur_y;
            r_out_btn <= r_btn;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_btn[1], r_out_btn[0], r_out_y, r_out_x};
    assign o_phase    = r_phase;

endmodule

`default_nettype wire

### rtl/mouse_packet_cursor_tracker_top.sv
// mouse_packet_cursor_tracker_top: top level, config registers plus core.
// Depends on mpct_pkg, mpct_cfg_regs, mpct_core.
//
//   port group   direction  content
//   i_s_*        in         one mouse byte per item
//   o_m_*        out        cursor position and buttons after each 3-byte group
//   apb (i_p*)   in/out     scale_mode @0x0, x_limit @0x4, y_limit @0x8
//
// one byte is accepted per cycle while no result waits on i_m_tready; each
// byte waits in the input register and its result, if any, is registered into
// the output register as the byte is processed. a result waiting on
// i_m_tready holds the byte behind it; input flows as long as results are taken.
// synchronous active-low reset: cursor at 320,240, right button set, phase 0.
`timescale 1ns / 1ps
`default_nettype none

module mouse_packet_cursor_tracker_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [23:0] o_m_tdata,   // [9:0] x_pos, [18:10] y_pos,
                                          // [19] left_button, [20] right_button
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [3:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic      [31:0] o_prdata,
    output logic             o_pready
);
    import mpct_pkg::*;

    t_cfg       cfg;
    logic [1:0] phase;

    mpct_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    mpct_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_phase    (phase)
    );

    a_phase_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        phase != 2'd3)
        else $error("byte phase reached unused code");

    a_x_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[9:0] <= cfg.x_limit)
        else $error("x_pos above x_limit");

    a_y_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[18:10] <= cfg.y_limit)
        else $error("y_pos above y_limit");

    a_result_after_third: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !$past(o_m_tvalid)) |-> $past(phase) == 2'd2 && phase == 2'd0)
        else $error("result without a third byte");

endmodule

`default_nettype wire

### dv/tb_top.sv
// tb_top: self-checking bench for mouse_packet_cursor_tracker_top, with a directed
// table then randomized byte streams across several register settings and flow-control
// patterns. Depends on mpct_pkg and the rtl under rtl/.
`timescale 1ns / 1ps

module tb_top;
    import mpct_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_SHOWN    = 10;

    // one report, packed as on o_m_tdata, fields listed from bit 20 down
    typedef struct packed {
        logic       right;
        logic       left;
        logic [8:0] y;
        logic [9:0] x;
    } t_cursor_report;

    typedef struct {
        logic [7:0]     b;
        bit             typed;
        t_cursor_report rep;
    } t_packet_row;

    typedef struct {
        logic       scale;
        logic [9:0] xlim;
        logic [8:0] ylim;
        int         tx_idle;
        int         rx_stall;
    } t_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic [7:0]  s_data;
    logic        m_ready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [23:0] o_m_tdata;
    wire  [31:0] o_prdata;
    wire         o_pready;

    mouse_packet_cursor_tracker_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    // tracker state as the bench sees it
    logic       cfg_scale;
    logic [9:0] cfg_xlim;
    logic [8:0] cfg_ylim;
    logic [1:0] grp_phase;
    logic [7:0] vert_byte;
    logic [1:0] btn_bits;
    int         cur_x;
    int         cur_y;

    t_cursor_report expected_reports[$];
    int             errors;
    int             cyc;
    int             tx_idle_pct;
    int             rx_stall_pct;
    bit             rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cyc = 0;
        while (cyc < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int delta_of(input logic [7:0] b);
        int d;
        d = $signed(b);
        if (cfg_scale) begin
            d = d / 4;
        end
        return d;
    endfunction

    function automatic int clamp_to(input int v, input int lim);
        if (v < 0) begin
            return 0;
        end
        return (v > lim) ? lim : v;
    endfunction

    // advance the tracker by one byte; a report comes out on the third byte of a group
    function automatic void track_byte(input logic [7:0] b, output bit has_rep,
                                       output t_cursor_report rep);
        has_rep = 1'b0;
        rep     = '0;
        if (grp_phase == 2'd1) begin
            btn_bits  = b[1:0];
            grp_phase = 2'd2;
        end else if (grp_phase != 2'd2) begin
            vert_byte = b;
            grp_phase = 2'd1;
        end else begin
            cur_x     = clamp_to(cur_x + delta_of(b), int'(cfg_xlim));
            cur_y     = clamp_to(cur_y - delta_of(vert_byte), int'(cfg_ylim));
            grp_phase = 2'd0;
            rep.x     = cur_x[9:0];
            rep.y     = cur_y[8:0];
            rep.left  = btn_bits[0];
            rep.right = btn_bits[1];
            has_rep   = 1'b1;
        end
    endfunction

    function automatic logic [7:0] pick_byte();
        if (grp_phase != 2'd1 && $urandom_range(4) == 0) begin
            case ($urandom_range(3))
                0: return 8'h80;
                1: return 8'h7F;
                2: return 8'h00;
                default: return 8'hFF;
            endcase
        end
        return 8'($urandom);
    endfunction

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input t_cursor_report typed_rep);
        bit             has_rep;
        t_cursor_report rep;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        track_byte(b, has_rep, rep);
        if (has_rep) begin
            expected_reports.push_back(typed ? typed_rep : rep);
        end
        @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        rdata = o_prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_check(input logic [1:0] idx, input logic [31:0] want);
        logic [31:0] got;
        apb_access(1'b0, idx, '0, got);
        if (got !== want) begin
            errors++;
            if (errors <= MAX_SHOWN) begin
                $display("register %0d readback: expected %0h, got %0h", idx, want, got);
            end
        end
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] unused;
        apb_access(1'b1, idx, val, unused);
        case (idx)
            REG_SCALE_MODE: cfg_scale = val[0];
            REG_X_LIMIT:    cfg_xlim  = val[9:0];
            REG_Y_LIMIT:    cfg_ylim  = val[8:0];
            default: ;
        endcase
        reg_check(idx, val);
    endtask

    // block is idle once every report is in and the pipe has emptied
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (rx_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_cursor_report got;
        t_cursor_report want;
        if (i_rst_n && o_m_tvalid && m_ready) begin
            got = o_m_tdata[20:0];
            if (expected_reports.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN) begin
                    $display("unexpected report x=%0d y=%0d l=%0b r=%0b",
                             got.x, got.y, got.left, got.right);
                end
            end else begin
                want = expected_reports.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= MAX_SHOWN) begin
                        $display({"report mismatch: expected x=%0d y=%0d l=%0b r=%0b,",
                                  " got x=%0d y=%0d l=%0b r=%0b"},
                                 want.x, want.y, want.left, want.right,
                                 got.x, got.y, got.left, got.right);
                    end
                end
            end
        end
    end

    t_packet_row packet_rows[24] = '{
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{1'b0, 1'b0, 9'd240, 10'd320}},
        // full-scale moves until both limits clamp
        '{8'h80, 1'b0, '0}, '{8'h03, 1'b0, '0},
        '{8'h7F, 1'b1, '{1'b1, 1'b1, 9'd368, 10'd447}},
        '{8'h80, 1'b0, '0}, '{8'h01, 1'b0, '0},
        '{8'h7F, 1'b1, '{1'b0, 1'b1, 9'd459, 10'd574}},
        '{8'h80, 1'b0, '0}, '{8'h02, 1'b0, '0},
        '{8'h7F, 1'b1, '{1'b1, 1'b0, 9'd459, 10'd628}},
        // walk back down, upper button-byte bits ignored
        '{8'h7F, 1'b0, '0}, '{8'hFC, 1'b0, '0}, '{8'h80, 1'b0, '0},
        '{8'h7F, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h80, 1'b0, '0},
        '{8'h7F, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h80, 1'b0, '0},
        '{8'h7F, 1'b0, '0}, '{8'h01, 1'b0, '0},
        '{8'h80, 1'b1, '{1'b0, 1'b1, 9'd0, 10'd116}}
    };

    t_phase phases[9] = '{
        '{1'b1, 10'd1023, 9'd511,  0,  0},
        '{1'b0, 10'd0,    9'd0,   65,  0},
        '{1'b1, 10'd628,  9'd459,  0, 65},
        '{1'b0, 10'd1023, 9'd511, 13, 13},
        '{1'b1, 10'd7,    9'd3,   65,  0},
        '{1'b0, 10'd320,  9'd240,  0,  0},
        '{1'b0, 10'd1,    9'd511,  0, 65},
        '{1'b1, 10'd1023, 9'd0,   13, 13},
        '{1'b0, 10'd628,  9'd459, 65, 65}
    };

    localparam int PRESSURE_PHASE = 5;

    initial begin
        int n_items;
        i_rst_n      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        rx_hold      = 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        errors       = 0;
        cfg_scale    = 1'b0;
        cfg_xlim     = X_LIMIT_RST;
        cfg_ylim     = Y_LIMIT_RST;
        grp_phase    = 2'd0;
        vert_byte    = '0;
        btn_bits     = BUTTONS_RST;
        cur_x        = CURSOR_X_RST;
        cur_y        = CURSOR_Y_RST;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        reg_check(REG_SCALE_MODE, 32'd0);
        reg_check(REG_X_LIMIT, 32'(X_LIMIT_RST));
        reg_check(REG_Y_LIMIT, 32'(Y_LIMIT_RST));

        foreach (packet_rows[i]) begin
            send_byte(packet_rows[i].b, packet_rows[i].typed, packet_rows[i].rep);
        end

        foreach (phases[p]) begin
            wait_idle();
            // phases of uneven length leave a group open across the writes
            reg_write(REG_SCALE_MODE, 32'(phases[p].scale));
            reg_write(REG_X_LIMIT, 32'(phases[p].xlim));
            reg_write(REG_Y_LIMIT, 32'(phases[p].ylim));
            tx_idle_pct  = phases[p].tx_idle;
            rx_stall_pct = phases[p].rx_stall;
            n_items = 115 + $urandom_range(2);
            for (int k = 0; k < n_items; k++) begin
                if (p == PRESSURE_PHASE && k == 30) begin
                    fork
                        begin
                            rx_hold = 1'b1;
                            repeat (200) @(posedge i_clk);
                            rx_hold = 1'b0;
                        end
                    join_none
                end
                if (p == PRESSURE_PHASE && k == 70) begin
                    s_valid <= 1'b0;
                    while (expected_reports.size() != 0) @(negedge i_clk);
                end
                send_byte(pick_byte(), 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
